[design/assert_macros.svh]
// Assertion shorthands for the parity count segment tree.
// Both forms sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pcst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcst_pkg
// Shared types and constants of the parity count segment tree.
// ----------------------------------------------------------------------------
package pcst_pkg;

	localparam int CNT_W  = 11;
	localparam int SIZE_W = 11;
	localparam int POS_W  = 10;
	localparam int END_W  = 11;
	// Node indices stay below twice the largest size the register can hold.
	localparam int IDX_W  = 12;
	// Largest size in use after reset.
	localparam int SIZE_CAP = 1024;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} pcst_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_LEAF,
		ST_UPD_SUM,
		ST_QRY_LEFT,
		ST_QRY_RIGHT,
		ST_DONE
	} pcst_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] odd;
		logic [CNT_W-1:0] even;
	} pcst_node_t;

	typedef struct packed {
		logic             err;
		logic [CNT_W-1:0] odd;
		logic [CNT_W-1:0] even;
	} pcst_result_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} pcst_status_t;

endpackage

[design/pcst_node_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcst_node_ram
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcst_node_ram
	import pcst_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pcst_node_t    wdata,
	input  logic [AW-1:0] raddr,
	output pcst_node_t    rdata
);

	pcst_node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/pcst_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcst_engine
// Size register and the sequencer that walks the tree in the node store.
// ----------------------------------------------------------------------------
module pcst_engine
	import pcst_pkg::*;
#(
	parameter int MAX_ITEMS = 1024,
	parameter int DEPTH     = 2048,
	parameter int AW        = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcst_op_t          in_op,
	input  logic [POS_W-1:0]  in_pos,
	input  logic [END_W-1:0]  in_end,
	input  logic              in_odd,
	output logic              res_valid,
	input  logic              res_ready,
	output pcst_result_t      res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output pcst_node_t        mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  pcst_node_t        mem_rdata,
	output pcst_status_t      status
);

	localparam logic [SIZE_W-1:0] SIZE_RESET =
		SIZE_W'((MAX_ITEMS < SIZE_CAP) ? MAX_ITEMS : SIZE_CAP);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
	localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

	pcst_state_t       state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [AW-1:0]     clr_q;
	logic              pend_q;
	logic [IDX_W-1:0]  l_q, r_q;
	pcst_node_t        cur_q, acc_q;
	logic              err_q, odd_q;

	logic [IDX_W-1:0]  pos_w, end_w, n_w, parent, r_dec;
	logic              in_err, l_lt_r;
	pcst_node_t        leaf, up_sum, acc_sum;

	function automatic pcst_node_t node_add(pcst_node_t a, pcst_node_t b);
		pcst_node_t s;
		s.even = a.even + b.even;
		s.odd  = a.odd + b.odd;
		return s;
	endfunction

	assign pos_w  = IDX_W'(in_pos);
	assign end_w  = IDX_W'(in_end);
	assign n_w    = IDX_W'(size_q);
	assign in_err = (in_op == OP_UPDATE) ? (pos_w >= n_w) : ((pos_w > n_w) || (end_w > n_w));

	assign parent  = l_q >> 1;
	assign r_dec   = r_q - ROOT;
	assign l_lt_r  = l_q < r_q;
	assign leaf    = '{odd: CNT_W'(odd_q), even: CNT_W'(!odd_q)};
	assign up_sum  = node_add(cur_q, mem_rdata);
	assign acc_sum = pend_q ? node_add(acc_q, mem_rdata) : acc_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_err) state_d = ST_DONE;
					else if (in_op == OP_QUERY) state_d = ST_QRY_LEFT;
					else state_d = ST_UPD_LEAF;
				end
			end
			ST_UPD_LEAF: begin
				state_d = (l_q == ROOT) ? ST_DONE : ST_UPD_SUM;
			end
			ST_UPD_SUM: begin
				if (parent == ROOT) state_d = ST_DONE;
			end
			ST_QRY_LEFT: begin
				state_d = l_lt_r ? ST_QRY_RIGHT : ST_DONE;
			end
			ST_QRY_RIGHT: begin
				state_d = ST_QRY_LEFT;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory and handshake controls. In the update states a write and a read in the
	// same cycle go to a node and its sibling, so they never collide.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(l_q);
		mem_wdata = leaf;
		mem_raddr = AW'(l_q);
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_UPD_LEAF: begin
				mem_we    = 1'b1;
				mem_raddr = AW'(l_q ^ ROOT);
			end
			ST_UPD_SUM: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(parent);
				mem_wdata = up_sum;
				mem_raddr = AW'(parent ^ ROOT);
			end
			ST_QRY_LEFT: begin
				mem_raddr = AW'(l_q);
			end
			ST_QRY_RIGHT: begin
				mem_raddr = AW'(r_dec);
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			size_q  <= SIZE_RESET;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_wdata != '0) && (int'(cfg_wdata) <= MAX_ITEMS)) begin
				size_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			unique case (state_q)
				ST_QRY_LEFT:  pend_q <= l_lt_r && l_q[0];
				ST_QRY_RIGHT: pend_q <= r_q[0];
				default:      pend_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					l_q   <= pos_w + n_w;
					r_q   <= end_w + n_w;
					acc_q <= '0;
					err_q <= in_err;
					odd_q <= in_odd;
				end
			end
			ST_UPD_LEAF: begin
				cur_q <= leaf;
			end
			ST_UPD_SUM: begin
				cur_q <= up_sum;
				l_q   <= parent;
			end
			ST_QRY_LEFT: begin
				acc_q <= acc_sum;
				if (l_lt_r && l_q[0]) l_q <= l_q + ROOT;
			end
			ST_QRY_RIGHT: begin
				acc_q <= acc_sum;
				l_q   <= l_q >> 1;
				r_q   <= (r_q[0] ? r_dec : r_q) >> 1;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign res.err  = err_q;
	assign res.odd  = acc_q.odd;
	assign res.even = acc_q.even;

	assign status.clearing = (state_q == ST_CLEAR);
	assign status.busy     = (state_q != ST_IDLE) && (state_q != ST_CLEAR);

endmodule

[design/parity_count_segment_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_count_segment_tree
// Bottom-up segment tree of even and odd counts with point updates and
// half-open range queries.
// ----------------------------------------------------------------------------
// After reset the node store is cleared one entry per cycle, all
// 2*MAX_ITEMS entries, and no word is accepted during that pass. The block
// then takes one word at a time. An update writes the leaf and then one
// parent per cycle. A query visits each tree level in a left-read state and
// then a right-read state, since the node store has a single read port and
// a level can need two nodes. A rejected index goes straight from idle to
// the done state. The finished result sits in the output register, so the
// next word is taken while it waits.
module parity_count_segment_tree
	import pcst_pkg::*;
#(
	parameter int MAX_ITEMS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,  // size_in_use
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [55:0]       s_tdata,    // position, range_end, value, zero pad
	input  logic              s_tuser,    // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,    // even_count, odd_count, zero pad
	output logic              m_tuser     // index_error
);

	`include "assert_macros.svh"

	localparam int NODE_DEPTH = 2 * MAX_ITEMS;
	localparam int AW         = $clog2(NODE_DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	pcst_node_t    mem_wdata, mem_rdata;
	logic          res_valid, res_ready;
	pcst_result_t  res, res_q;
	logic          m_tvalid_q;
	pcst_status_t  status;

	pcst_engine #(
		.MAX_ITEMS(MAX_ITEMS),
		.DEPTH    (NODE_DEPTH),
		.AW       (AW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (pcst_op_t'(s_tuser)),
		.in_pos   (s_tdata[9:0]),
		.in_end   (s_tdata[20:10]),
		.in_odd   (s_tdata[21]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.status   (status)
	);

	pcst_node_ram #(
		.DEPTH(NODE_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register: it frees up when empty or when its word is taken.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.odd, res_q.even};
	assign m_tuser  = res_q.err;

	`PCST_ASSERT_NOW(a_no_accept_while_clearing, status.clearing, !s_tready,
		"word accepted during the clearing pass")
	`PCST_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, status.busy && !s_tready,
		"engine not busy after accepting a word")
	`PCST_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid,
		"finished result dropped before the output register took it")
	`PCST_ASSERT_NOW(a_error_counts_zero, m_tvalid && m_tuser, m_tdata[2*CNT_W-1:0] == '0,
		"index error reported with nonzero counts")

endmodule
